### hw/rtl/cpu8_alu_with_flags_macros.svh
// Assertion macros for the 8-bit ALU block.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef CPU8_ALU_WITH_FLAGS_MACROS_SVH
`define CPU8_ALU_WITH_FLAGS_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define C8_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c8alu same-cycle check failed");
// Next-cycle implication check.
`define C8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c8alu next-cycle check failed");
`else
`define C8_ASSERT_SAME(label, clk, rst, ante, cons)
`define C8_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/c8alu_pkg.sv
// Shared types, command codes and constants of the 8-bit ALU block.
// No dependencies; used by every module.
package c8alu_pkg;

  localparam logic [4:0] CMD_ADD     = 5'd0;
  localparam logic [4:0] CMD_ADC     = 5'd1;
  localparam logic [4:0] CMD_SUB     = 5'd2;
  localparam logic [4:0] CMD_SBC     = 5'd3;
  localparam logic [4:0] CMD_AND     = 5'd4;
  localparam logic [4:0] CMD_OR      = 5'd5;
  localparam logic [4:0] CMD_XOR     = 5'd6;
  localparam logic [4:0] CMD_CP      = 5'd7;
  localparam logic [4:0] CMD_DAA     = 5'd8;
  localparam logic [4:0] CMD_CPL     = 5'd9;
  localparam logic [4:0] CMD_CCF     = 5'd10;
  localparam logic [4:0] CMD_SCF     = 5'd11;
  localparam logic [4:0] CMD_INC     = 5'd12;
  localparam logic [4:0] CMD_DEC     = 5'd13;
  localparam logic [4:0] CMD_RLC     = 5'd14;
  localparam logic [4:0] CMD_RRC     = 5'd15;
  localparam logic [4:0] CMD_RL      = 5'd16;
  localparam logic [4:0] CMD_RR      = 5'd17;
  localparam logic [4:0] CMD_SLA     = 5'd18;
  localparam logic [4:0] CMD_SRA     = 5'd19;
  localparam logic [4:0] CMD_SRL     = 5'd20;
  localparam logic [4:0] CMD_SWAP    = 5'd21;
  localparam logic [4:0] CMD_BIT     = 5'd22;
  localparam logic [4:0] CMD_RES     = 5'd23;
  localparam logic [4:0] CMD_SET     = 5'd24;
  localparam logic [4:0] CMD_ADD_HL  = 5'd25;
  localparam logic [4:0] CMD_ADD_SP  = 5'd26;
  localparam logic [4:0] CMD_INC_W   = 5'd27;
  localparam logic [4:0] CMD_DEC_W   = 5'd28;
  localparam logic [4:0] CMD_LOAD    = 5'd29;

  localparam logic [7:0] DAA_LIMIT   = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [3:0] DIGIT_MAX   = 4'h9;
  localparam logic [3:0] NIBBLE_MAX  = 4'hF;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [7:0]  operand;
    logic [2:0]  bit_index;
    logic [15:0] word_base;
    logic [15:0] word_operand;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    flags_t      flags;
  } result_item_t;

endpackage

### hw/rtl/c8alu_cmd_if.sv
// Command channel of the 8-bit ALU: valid/ready handshake plus command fields.
// Depends on nothing but the handshake convention (beat on valid and ready).
interface c8alu_cmd_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [7:0]  operand;
  logic [2:0]  bit_index;
  logic [15:0] word_base;
  logic [15:0] word_operand;

  modport source (output valid, cmd, operand, bit_index, word_base, word_operand,
                  input ready);
  modport sink   (input valid, cmd, operand, bit_index, word_base, word_operand,
                  output ready);
endinterface

### hw/rtl/c8alu_res_if.sv
// Result channel of the 8-bit ALU: valid/ready handshake plus result fields.
// Depends on nothing but the handshake convention (beat on valid and ready).
interface c8alu_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_byte;
  logic [15:0] result_word;
  logic        zero_flag;
  logic        subtract_flag;
  logic        half_carry_flag;
  logic        carry_flag;

  modport source (output valid, result_byte, result_word, zero_flag, subtract_flag,
                  half_carry_flag, carry_flag, input ready);
  modport sink   (input valid, result_byte, result_word, zero_flag, subtract_flag,
                  half_carry_flag, carry_flag, output ready);
endinterface

### hw/rtl/c8alu_in_stage.sv
// Input register of the 8-bit ALU: captures one command beat per cycle while not stalled.
// Depends on c8alu_pkg and c8alu_cmd_if.
module c8alu_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  c8alu_cmd_if.sink             request,
  input  logic                  advance,
  output logic                  valid,
  output c8alu_pkg::cmd_item_t  item
);
  import c8alu_pkg::*;

  // The stage refills whenever it is empty or its item moves on this cycle.
  assign request.ready = advance || !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (request.ready) begin
      valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready && request.valid) begin
      item.cmd          <= request.cmd;
      item.operand      <= request.operand;
      item.bit_index    <= request.bit_index;
      item.word_base    <= request.word_base;
      item.word_operand <= request.word_operand;
    end
  end
endmodule

### hw/rtl/c8alu_exec.sv
// Execute logic of the 8-bit ALU: holds the accumulator and flags and
// computes one result per command. Depends on c8alu_pkg and the macro header.
`include "cpu8_alu_with_flags_macros.svh"

module c8alu_exec (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  input  logic                     advance,
  input  c8alu_pkg::cmd_item_t     item,
  output c8alu_pkg::result_item_t  result
);
  import c8alu_pkg::*;

  logic [7:0] acc;
  flags_t     flags;
  logic [7:0] acc_next;
  flags_t     flags_next;
  logic       acc_we;

  logic [7:0]  op;
  logic        add_cin;
  logic        sub_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_nib;
  logic        daa_c;
  logic        daa_lo;
  logic [7:0]  daa_hi;
  logic [7:0]  daa_add;
  logic [7:0]  daa_sub;
  logic [7:0]  bit_mask;
  logic [16:0] hl_sum;
  logic [12:0] hl_low;
  logic [15:0] sp_sum;
  logic [4:0]  sp_nib;
  logic [8:0]  sp_low;
  logic [7:0]  rb;
  logic [15:0] rw;

  assign op      = item.operand;
  assign add_cin = (item.cmd == CMD_ADC) && flags.c;
  assign sub_cin = (item.cmd == CMD_SBC) && flags.c;

  assign add_sum  = {1'b0, acc} + {1'b0, op} + {8'b0, add_cin};
  assign add_nib  = {1'b0, acc[3:0]} + {1'b0, op[3:0]} + {4'b0, add_cin};
  // A borrow shows up as the sign bit of the one-bit-wider difference.
  assign sub_diff = {1'b0, acc} - {1'b0, op} - {8'b0, sub_cin};
  assign sub_nib  = {1'b0, acc[3:0]} - {1'b0, op[3:0]} - {4'b0, sub_cin};

  assign daa_c   = flags.c || (acc > DAA_LIMIT);
  assign daa_hi  = acc + (daa_c ? DAA_HI_ADJ : 8'h00);
  assign daa_lo  = flags.h || (acc[3:0] > DIGIT_MAX);
  assign daa_add = daa_hi + (daa_lo ? DAA_LO_ADJ : 8'h00);
  assign daa_sub = acc - (flags.c ? DAA_HI_ADJ : 8'h00) - (flags.h ? DAA_LO_ADJ : 8'h00);

  assign bit_mask = 8'b1 << item.bit_index;

  assign hl_sum = {1'b0, item.word_base} + {1'b0, item.word_operand};
  assign hl_low = {1'b0, item.word_base[11:0]} + {1'b0, item.word_operand[11:0]};
  assign sp_sum = item.word_base + {{8{op[7]}}, op};
  assign sp_nib = {1'b0, item.word_base[3:0]} + {1'b0, op[3:0]};
  assign sp_low = {1'b0, item.word_base[7:0]} + {1'b0, op};

  always_comb begin
    rb         = acc;
    rw         = 16'h0000;
    flags_next = flags;
    acc_we     = 1'b0;
    case (item.cmd)
      CMD_ADD, CMD_ADC: begin
        rb         = add_sum[7:0];
        flags_next = '{z: (add_sum[7:0] == 8'h00), n: 1'b0, h: add_nib[4], c: add_sum[8]};
        acc_we     = 1'b1;
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        flags_next = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1, h: sub_nib[4], c: sub_diff[8]};
        if (item.cmd != CMD_CP) begin
          rb     = sub_diff[7:0];
          acc_we = 1'b1;
        end
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        if (item.cmd == CMD_AND) begin
          rb = acc & op;
        end else if (item.cmd == CMD_OR) begin
          rb = acc | op;
        end else begin
          rb = acc ^ op;
        end
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: (item.cmd == CMD_AND), c: 1'b0};
        acc_we     = 1'b1;
      end
      CMD_DAA: begin
        // Subtraction keeps the carry; addition may only set it.
        rb           = flags.n ? daa_sub : daa_add;
        flags_next.z = (rb == 8'h00);
        flags_next.h = 1'b0;
        flags_next.c = flags.n ? flags.c : daa_c;
        acc_we       = 1'b1;
      end
      CMD_CPL: begin
        rb           = ~acc;
        flags_next.n = 1'b1;
        flags_next.h = 1'b1;
        acc_we       = 1'b1;
      end
      CMD_CCF: begin
        flags_next.n = 1'b0;
        flags_next.h = 1'b0;
        flags_next.c = !flags.c;
      end
      CMD_SCF: begin
        flags_next.n = 1'b0;
        flags_next.h = 1'b0;
        flags_next.c = 1'b1;
      end
      CMD_INC: begin
        rb           = op + 8'h01;
        flags_next.z = (rb == 8'h00);
        flags_next.n = 1'b0;
        flags_next.h = (op[3:0] == NIBBLE_MAX);
      end
      CMD_DEC: begin
        rb           = op - 8'h01;
        flags_next.z = (rb == 8'h00);
        flags_next.n = 1'b1;
        flags_next.h = (op[3:0] == 4'h0);
      end
      CMD_RLC: begin
        rb         = {op[6:0], op[7]};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: op[7]};
      end
      CMD_RRC: begin
        rb         = {op[0], op[7:1]};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: op[0]};
      end
      CMD_RL: begin
        rb         = {op[6:0], flags.c};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: op[7]};
      end
      CMD_RR: begin
        rb         = {flags.c, op[7:1]};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: op[0]};
      end
      CMD_SLA: begin
        rb         = {op[6:0], 1'b0};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: op[7]};
      end
      CMD_SRA: begin
        rb         = {op[7], op[7:1]};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: op[0]};
      end
      CMD_SRL: begin
        rb         = {1'b0, op[7:1]};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: op[0]};
      end
      CMD_SWAP: begin
        rb         = {op[3:0], op[7:4]};
        flags_next = '{z: (rb == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_BIT: begin
        rb           = op;
        flags_next.z = !op[item.bit_index];
        flags_next.n = 1'b0;
        flags_next.h = 1'b1;
      end
      CMD_RES: begin
        rb = op & ~bit_mask;
      end
      CMD_SET: begin
        rb = op | bit_mask;
      end
      CMD_ADD_HL: begin
        rw           = hl_sum[15:0];
        flags_next.n = 1'b0;
        flags_next.h = hl_low[12];
        flags_next.c = hl_sum[16];
      end
      CMD_ADD_SP: begin
        // Flags come from the unsigned add of the low byte.
        rw         = sp_sum;
        flags_next = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp_low[8]};
      end
      CMD_INC_W: begin
        rw = item.word_base + 16'h0001;
      end
      CMD_DEC_W: begin
        rw = item.word_base - 16'h0001;
      end
      CMD_LOAD: begin
        rb         = item.word_operand[15:8];
        flags_next = flags_t'(item.word_operand[7:4]);
        acc_we     = 1'b1;
      end
      default: begin
        rb = acc;
      end
    endcase
  end

  assign acc_next = acc_we ? rb : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 8'h00;
      flags <= '0;
    end else if (valid && advance) begin
      acc   <= acc_next;
      flags <= flags_next;
    end
  end

  assign result.result_byte = rb;
  assign result.result_word = rw;
  assign result.flags       = flags_next;

  `C8_ASSERT_NEXT(state_holds_when_idle, clk, rst, !(valid && advance), $stable(acc) && $stable(flags))
  `C8_ASSERT_NEXT(load_sets_state, clk, rst, valid && advance && item.cmd == CMD_LOAD, acc == $past(item.word_operand[15:8]) && flags == $past(item.word_operand[7:4]))
  `C8_ASSERT_NEXT(compare_keeps_acc, clk, rst, valid && advance && item.cmd == CMD_CP, acc == $past(acc))
endmodule

### hw/rtl/c8alu_out_stage.sv
// Result register of the 8-bit ALU: holds a finished result until taken.
// Depends on c8alu_pkg and c8alu_res_if.
module c8alu_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  input  c8alu_pkg::result_item_t  result,
  output logic                     advance,
  c8alu_res_if.source              response
);
  import c8alu_pkg::*;

  result_item_t held;

  // The register may load when empty or when its beat leaves this cycle.
  assign advance = !response.valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (advance) begin
      response.valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid) begin
      held <= result;
    end
  end

  assign response.result_byte     = held.result_byte;
  assign response.result_word     = held.result_word;
  assign response.zero_flag       = held.flags.z;
  assign response.subtract_flag   = held.flags.n;
  assign response.half_carry_flag = held.flags.h;
  assign response.carry_flag      = held.flags.c;
endmodule

### hw/rtl/cpu8_alu_with_flags.sv
// 8-bit CPU ALU with accumulator and Z, N, H, C flags.
// Commands arrive on the request channel, one beat per command; each command
// produces exactly one result beat on the response channel, in order.
// Both channels use valid/ready; a beat moves when both are high.
// A command is held in one input register, runs through the
// combinational execute logic, and its result is held in one result
// register, which drives the response channel.
// Throughput: one command per cycle when not stalled. The accumulator and
// flags are updated in the same cycle the command passes the execute logic,
// so back-to-back commands see each other's results without a bubble.
// Reset (rst, synchronous) clears the accumulator, all flags and the valid
// bits of both pipeline registers; their data is not reset.
// When the receiver holds ready low, the result register keeps its beat and
// the input register still takes one more command if empty; then request.ready
// drops until the response channel drains.
// Depends on c8alu_pkg, the two channel interfaces and the macro header.
`include "cpu8_alu_with_flags_macros.svh"

module cpu8_alu_with_flags (
  input  logic         clk,
  input  logic         rst,
  c8alu_cmd_if.sink    request,
  c8alu_res_if.source  response
);
  import c8alu_pkg::*;

  logic         s1_valid;
  logic         advance;
  cmd_item_t    s1_item;
  result_item_t s1_result;

  c8alu_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .advance (advance),
    .valid   (s1_valid),
    .item    (s1_item)
  );

  c8alu_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .valid   (s1_valid),
    .advance (advance),
    .item    (s1_item),
    .result  (s1_result)
  );

  c8alu_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .valid    (s1_valid),
    .result   (s1_result),
    .advance  (advance),
    .response (response)
  );

  `C8_ASSERT_SAME(stall_means_full, clk, rst, !request.ready, s1_valid && response.valid && !response.ready)
  `C8_ASSERT_SAME(result_has_source, clk, rst, $rose(response.valid), $past(s1_valid))
endmodule
